>>> rtl/smmm_pkg.sv
package smmm_pkg;

    // Set capacity and sample width.
    localparam int MAX_SAMPLES = 32;
    localparam int SAMPLE_BITS = 20;

    // Derived widths: the count must hold MAX_SAMPLES itself, the sum must hold
    // MAX_SAMPLES full-scale samples.
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int SUM_W  = SAMPLE_BITS + IDX_W;
    localparam int STEP_W = $clog2(SUM_W + 1);

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [CNT_W-1:0]       t_count;
    typedef logic [IDX_W-1:0]       t_index;
    typedef logic [SUM_W-1:0]       t_sum;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // a sample request is taken this cycle
        logic rd_a;       // read the lower middle entry of the sorted store
        logic rd_b;       // read the upper middle entry of the sorted store
        logic div_start;  // start the mean division
        logic capture;    // load the result registers and clear the set
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
    } t_dp_status;

endpackage

>>> rtl/smmm_divider.sv
module smmm_divider (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  smmm_pkg::t_sum   i_dividend,
    input  smmm_pkg::t_count i_divisor,
    output smmm_pkg::t_sum   o_quotient,
    output logic            o_busy
);
    import smmm_pkg::*;

    // Restoring divider, one quotient bit per cycle. The dividend is shifted
    // out of the top of r_quo while quotient bits enter at the bottom.
    logic                r_busy;
    logic [STEP_W-1:0]   r_step;
    t_count              r_rem;
    t_sum                r_quo;
    t_count              r_div;

    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      diff;
    logic                fits;
    t_count              n_rem;

    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
        n_rem = fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(SUM_W);
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quo  <= {r_quo[SUM_W-2:0], fits};
            r_step <= r_step - 1'b1;
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_busy     = r_busy;

endmodule

>>> rtl/smmm_datapath.sv
module smmm_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  smmm_pkg::t_dp_cmd    i_cmd,
    output smmm_pkg::t_dp_status o_status,
    input  smmm_pkg::t_sample    i_sample,
    output smmm_pkg::t_sample    o_minimum,
    output smmm_pkg::t_sample    o_maximum,
    output smmm_pkg::t_sample    o_mean,
    output smmm_pkg::t_sample    o_median,
    output smmm_pkg::t_count     o_sample_count,
    output logic                o_overflow
);
    import smmm_pkg::*;

    // Sorted row of cells; entries at or above r_count hold stale data.
    t_sample r_store [MAX_SAMPLES];
    t_sample n_store [MAX_SAMPLES];
    logic [MAX_SAMPLES-1:0] gt;

    t_count  r_count;
    t_sum    r_sum;
    t_sample r_min;
    t_sample r_max;
    logic    r_drop;

    t_sample r_med_a;
    t_sample r_med_b;

    t_sample r_res_min;
    t_sample r_res_max;
    t_sample r_res_mean;
    t_sample r_res_median;
    t_count  r_res_count;
    logic    r_res_drop;

    logic    full;
    t_count  half;
    t_index  idx_a;
    t_index  idx_b;
    t_index  rd_idx;
    t_sample rd_data;
    logic [SAMPLE_BITS:0] med_sum;
    t_sum    quotient;
    logic    div_busy;

    // Each cell compares itself with the new sample; cells above the insert
    // point take their lower neighbor, the insert point takes the sample.
    always_comb begin
        full = (r_count == CNT_W'(MAX_SAMPLES));
        for (int i = 0; i < MAX_SAMPLES; i++) begin
            gt[i] = (CNT_W'(i) < r_count) && (r_store[i] > i_sample);
        end
        if (gt[0] || (r_count == '0)) begin
            n_store[0] = i_sample;
        end else begin
            n_store[0] = r_store[0];
        end
        for (int i = 1; i < MAX_SAMPLES; i++) begin
            if (gt[i-1]) begin
                n_store[i] = r_store[i-1];
            end else if (gt[i] || (CNT_W'(i) == r_count)) begin
                n_store[i] = i_sample;
            end else begin
                n_store[i] = r_store[i];
            end
        end
    end

    // Median read through one port: for an odd count both reads hit the middle.
    always_comb begin
        half    = r_count >> 1;
        idx_b   = half[IDX_W-1:0];
        idx_a   = r_count[0] ? idx_b : idx_b - 1'b1;
        rd_idx  = i_cmd.rd_b ? idx_b : idx_a;
        rd_data = r_store[rd_idx];
        med_sum = {1'b0, r_med_a} + {1'b0, r_med_b};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !full) begin
            r_store <= n_store;
        end
        if (i_cmd.rd_a) begin
            r_med_a <= rd_data;
        end
        if (i_cmd.rd_b) begin
            r_med_b <= rd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.capture) begin
            r_count <= '0;
            r_sum   <= '0;
            r_min   <= '1;
            r_max   <= '0;
            r_drop  <= 1'b0;
        end else if (i_cmd.load) begin
            if (full) begin
                r_drop <= 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
                r_sum   <= r_sum + SUM_W'(i_sample);
                if (i_sample < r_min) begin
                    r_min <= i_sample;
                end
                if (i_sample > r_max) begin
                    r_max <= i_sample;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_res_min    <= r_min;
            r_res_max    <= r_max;
            r_res_mean   <= quotient[SAMPLE_BITS-1:0];
            r_res_median <= med_sum[SAMPLE_BITS:1];
            r_res_count  <= r_count;
            r_res_drop   <= r_drop;
        end
    end

    smmm_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_quotient (quotient),
        .o_busy     (div_busy)
    );

    assign o_status.div_busy = div_busy;
    assign o_minimum         = r_res_min;
    assign o_maximum         = r_res_max;
    assign o_mean            = r_res_mean;
    assign o_median          = r_res_median;
    assign o_sample_count    = r_res_count;
    assign o_overflow        = r_res_drop;

endmodule

>>> rtl/smmm_ctrl.sv
module smmm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_last,
    output logic                o_ready,
    output logic                o_valid,
    input  logic                i_ready,
    output smmm_pkg::t_dp_cmd    o_cmd,
    input  smmm_pkg::t_dp_status i_status
);
    import smmm_pkg::*;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_MED_A,
        S_MED_B,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    always_comb begin
        o_ready  = (r_state == S_COLLECT);
        accept   = i_valid && o_ready;
        out_free = !r_out_valid || i_ready;

        o_cmd           = '0;
        o_cmd.load      = accept;
        o_cmd.rd_a      = (r_state == S_MED_A);
        o_cmd.div_start = (r_state == S_MED_A);
        o_cmd.rd_b      = (r_state == S_MED_B);
        o_cmd.capture   = (r_state == S_OUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.capture) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_COLLECT: begin
                    if (accept && i_last) begin
                        r_state <= S_MED_A;
                    end
                end
                S_MED_A: begin
                    r_state <= S_MED_B;
                end
                S_MED_B: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (!i_status.div_busy) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_COLLECT;
                    end
                end
                default: begin
                    r_state <= S_COLLECT;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;

endmodule

>>> rtl/sample_min_max_mean_median.sv
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_ready   i_sample, i_last
// result    out        o_valid / i_ready   o_minimum, o_maximum, o_mean, o_median,
//                                          o_sample_count, o_overflow
//
// Samples are taken one per cycle, while o_ready is high, into a sorted row of
// cells; a sample that arrives with the set already full is dropped and flagged.
// After the request that carries i_last, the input is held off while the two
// middle entries are read and while the mean comes from a restoring divider
// that yields one quotient bit per cycle. The result sits in an output register,
// so a new set can load while it waits to be taken; closing that set waits
// until the register is free. Reset is synchronous and active low; it clears
// the set and the output valid.

module sample_min_max_mean_median (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  smmm_pkg::t_sample i_sample,
    input  logic             i_last,
    output logic             o_valid,
    input  logic             i_ready,
    output smmm_pkg::t_sample o_minimum,
    output smmm_pkg::t_sample o_maximum,
    output smmm_pkg::t_sample o_mean,
    output smmm_pkg::t_sample o_median,
    output smmm_pkg::t_count  o_sample_count,
    output logic             o_overflow
);
    import smmm_pkg::*;

    // The controller sequences the set closing; the datapath holds the store,
    // the running statistics, the divider and the result registers.
    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    smmm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_last   (i_last),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (dp_cmd),
        .i_status (dp_status)
    );

    smmm_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_status       (dp_status),
        .i_sample       (i_sample),
        .o_minimum      (o_minimum),
        .o_maximum      (o_maximum),
        .o_mean         (o_mean),
        .o_median       (o_median),
        .o_sample_count (o_sample_count),
        .o_overflow     (o_overflow)
    );

endmodule

>>> rtl/smmm_checker.sv
module smmm_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_ready,
    input smmm_pkg::t_sample o_minimum,
    input smmm_pkg::t_sample o_maximum,
    input smmm_pkg::t_sample o_mean,
    input smmm_pkg::t_sample o_median,
    input smmm_pkg::t_count  o_sample_count
);
    import smmm_pkg::*;

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its statistics.
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_mean) && $stable(o_median)
                                && $stable(o_minimum) && $stable(o_maximum))
        else $error("result changed while stalled");

    // Mean and median lie between the extremes of the set.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_minimum <= o_maximum) && (o_mean >= o_minimum)
                    && (o_mean <= o_maximum) && (o_median >= o_minimum)
                    && (o_median <= o_maximum))
        else $error("statistics out of order");

    // A result always covers at least one and at most a full store of samples.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sample_count != '0)
                    && (o_sample_count <= CNT_W'(MAX_SAMPLES)))
        else $error("sample count out of range");

endmodule

bind sample_min_max_mean_median smmm_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_minimum      (o_minimum),
    .o_maximum      (o_maximum),
    .o_mean         (o_mean),
    .o_median       (o_median),
    .o_sample_count (o_sample_count)
);
